// ===== hw/rtl/reflow_oven_sequencer_top_defines.svh =====
// Assertion macros for the reflow oven sequencer.
`ifndef REFLOW_OVEN_SEQUENCER_TOP_DEFINES_SVH
`define REFLOW_OVEN_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on clk, off during rst.
`define ROS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("reflow oven sequencer check failed");
// Next-cycle implication, checked on clk, off during rst.
`define ROS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("reflow oven sequencer check failed");
`else
`define ROS_ASSERT_IMPL(label, ante, cons)
`define ROS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/ros_pkg.sv =====
// Types, constants and helper functions of the reflow oven sequencer.
`default_nettype none
package ros_pkg;

  localparam int PROFILE_COUNT = 4;
  localparam logic [2:0] PROFILE_LAST = 3'(PROFILE_COUNT - 1);
  localparam logic [15:0] MS_PER_SECOND = 16'd1000;
  localparam logic [15:0] SAT16 = 16'hFFFF;

  localparam int TEMP_W = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROOM     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREHEAT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOAK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REFLOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COOL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd5;

  // Button events
  localparam logic [1:0] BTN_SHORT = 2'd1;
  localparam logic [1:0] BTN_LONG  = 2'd2;

  // Zones
  localparam logic [1:0] ZN_PREHEAT = 2'd0;
  localparam logic [1:0] ZN_SOAK    = 2'd1;
  localparam logic [1:0] ZN_REFLOW  = 2'd2;
  localparam logic [1:0] ZN_COOL    = 2'd3;

  // Reported state codes
  localparam logic [3:0] CODE_PROFILE  = 4'd0;
  localparam logic [3:0] CODE_RESET    = 4'd1;
  localparam logic [3:0] CODE_DEBUG    = 4'd2;
  localparam logic [3:0] CODE_ABORT    = 4'd3;
  localparam logic [3:0] CODE_IDLE     = 4'd4;
  localparam logic [3:0] CODE_START    = 4'd5;
  localparam logic [3:0] CODE_PREHEAT  = 4'd6;
  localparam logic [3:0] CODE_SOAK     = 4'd7;
  localparam logic [3:0] CODE_REFLOW   = 4'd8;
  localparam logic [3:0] CODE_COOL     = 4'd9;
  localparam logic [3:0] CODE_COMPLETE = 4'd10;
  localparam logic [3:0] CODE_HOT      = 4'd11;
  localparam logic [3:0] CODE_ERROR    = 4'd12;

  typedef enum logic [11:0] {
    ST_PROFILE  = 12'b0000_0000_0001,
    ST_RESET    = 12'b0000_0000_0010,
    ST_DEBUG    = 12'b0000_0000_0100,
    ST_ABORT    = 12'b0000_0000_1000,
    ST_IDLE     = 12'b0000_0001_0000,
    ST_START    = 12'b0000_0010_0000,
    ST_PREHEAT  = 12'b0000_0100_0000,
    ST_SOAK     = 12'b0000_1000_0000,
    ST_REFLOW   = 12'b0001_0000_0000,
    ST_COOL     = 12'b0010_0000_0000,
    ST_COMPLETE = 12'b0100_0000_0000,
    ST_HOT      = 12'b1000_0000_0000
  } state_t;

  typedef struct packed {
    logic [TEMP_W-1:0] room_temp;
    logic [TEMP_W-1:0] preheat_temp;
    logic [TEMP_W-1:0] soak_temp;
    logic [TEMP_W-1:0] reflow_temp;
    logic [TEMP_W-1:0] cool_temp;
    logic [15:0]       interval_ms;
  } cfg_t;

  function automatic logic [TEMP_W-1:0] zone_target(cfg_t c, logic [1:0] z);
    logic [TEMP_W-1:0] t;
    unique case (z)
      ZN_PREHEAT: t = c.preheat_temp;
      ZN_SOAK:    t = c.soak_temp;
      ZN_REFLOW:  t = c.reflow_temp;
      default:    t = c.cool_temp;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] state_code(state_t s);
    logic [3:0] c;
    unique case (s)
      ST_PROFILE:  c = CODE_PROFILE;
      ST_RESET:    c = CODE_RESET;
      ST_DEBUG:    c = CODE_DEBUG;
      ST_ABORT:    c = CODE_ABORT;
      ST_IDLE:     c = CODE_IDLE;
      ST_START:    c = CODE_START;
      ST_PREHEAT:  c = CODE_PREHEAT;
      ST_SOAK:     c = CODE_SOAK;
      ST_REFLOW:   c = CODE_REFLOW;
      ST_COOL:     c = CODE_COOL;
      ST_COMPLETE: c = CODE_COMPLETE;
      ST_HOT:      c = CODE_HOT;
      default:     c = CODE_ERROR;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] sat_inc16(logic [15:0] v);
    return (v == SAT16) ? SAT16 : v + 16'd1;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ros_channels.sv =====
// Handshake channel interfaces of the reflow oven sequencer.
`default_nettype none
interface ros_sample_if;
  logic                        valid;
  logic                        ready;
  logic [ros_pkg::TEMP_W-1:0]  temperature;
  logic                        debug_mode;
  logic [1:0]                  button;
  logic                        start_cmd;
  logic                        stop_cmd;
  modport source (output valid, temperature, debug_mode, button, start_cmd, stop_cmd,
                  input ready);
  modport sink   (input valid, temperature, debug_mode, button, start_cmd, stop_cmd,
                  output ready);
endinterface

interface ros_result_if;
  logic                        valid;
  logic                        ready;
  logic [3:0]                  state_code;
  logic                        run_on;
  logic [1:0]                  zone_code;
  logic                        pid_on;
  logic [ros_pkg::TEMP_W-1:0]  setpoint;
  logic                        fan_on;
  logic [2:0]                  profile_number;
  logic [15:0]                 run_seconds;
  logic [15:0]                 zone_seconds;
  modport source (output valid, state_code, run_on, zone_code, pid_on, setpoint, fan_on,
                         profile_number, run_seconds, zone_seconds,
                  input ready);
  modport sink   (input valid, state_code, run_on, zone_code, pid_on, setpoint, fan_on,
                        profile_number, run_seconds, zone_seconds,
                  output ready);
endinterface

interface ros_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ros_pkg::CFG_IDX_W-1:0]   index;
  logic [ros_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/reflow_oven_sequencer_top.sv =====
// Top level of the reflow oven sequencer: input stage, state update, result register.
// A sample waits in the input register; its result then loads the result register.
// Throughput: one sample per cycle unless result.ready stalls the result register;
// the single-pass state update between input and result register sets that figure.
// Reset: rst is synchronous and active high; it clears the state, the counters,
// both valid flags and loads the configuration defaults. No clearing pass.
`default_nettype none
`include "reflow_oven_sequencer_top_defines.svh"
module reflow_oven_sequencer_top (
  input  wire logic  clk,
  input  wire logic  rst,
  ros_sample_if.sink sample,
  ros_result_if.source result,
  ros_cfg_if.sink    cfg
);

  ros_pkg::cfg_t regs;

  ros_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // ---------------------------------------------------------------------------
  // Input stage: hold one sample until the result register can take its result.
  // ---------------------------------------------------------------------------
  logic                       s_valid;
  logic [ros_pkg::TEMP_W-1:0] s_temp;
  logic                       s_debug;
  logic [1:0]                 s_button;
  logic                       s_start;
  logic                       s_stop;
  logic                       advance;

  assign advance      = s_valid && (!result.valid || result.ready);
  assign sample.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s_temp   <= sample.temperature;
      s_debug  <= sample.debug_mode;
      s_button <= sample.button;
      s_start  <= sample.start_cmd;
      s_stop   <= sample.stop_cmd;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  ros_pkg::state_t state, state_next;
  logic        run_flag, run_flag_next;
  logic [1:0]  zone, zone_next;
  logic        pid_en, pid_en_next;
  logic        fan, fan_next;
  logic        start_pending, start_pending_next;
  logic [15:0] second_count, second_count_next;
  logic [15:0] interval_count, interval_count_next;
  logic [15:0] run_count, run_count_next;
  logic [15:0] zone_count, zone_count_next;
  logic [2:0]  profile, profile_next;
  logic [ros_pkg::TEMP_W-1:0] step_target;
  logic        btn_long;
  logic        btn_short;

  assign btn_long  = !s_debug && (s_button == ros_pkg::BTN_LONG);
  assign btn_short = !s_debug && (s_button == ros_pkg::BTN_SHORT);

  // The zone is not touched before the step, so its target comes from the
  // current zone register.
  assign step_target = ros_pkg::zone_target(regs, zone);

  always_comb begin
    state_next          = state;
    run_flag_next       = run_flag;
    zone_next           = zone;
    pid_en_next         = pid_en;
    fan_next            = fan;
    start_pending_next  = start_pending;
    run_count_next      = run_count;
    zone_count_next     = zone_count;
    profile_next        = profile;

    // Advance both millisecond counters, saturating.
    second_count_next   = ros_pkg::sat_inc16(second_count);
    interval_count_next = ros_pkg::sat_inc16(interval_count);

    // Serial requests: start only latches in idle, stop only aborts a run.
    if (s_start && state == ros_pkg::ST_IDLE) begin
      start_pending_next = 1'b1;
    end
    if (s_stop && run_flag) begin
      state_next          = ros_pkg::ST_ABORT;
      run_flag_next       = 1'b0;
      interval_count_next = '0;
    end

    // Button events, ignored in debug mode; code three counts as no event.
    if (btn_long) begin
      if (state_next == ros_pkg::ST_IDLE) begin
        state_next = ros_pkg::ST_PROFILE;
      end else if (run_flag_next) begin
        state_next    = ros_pkg::ST_ABORT;
        run_flag_next = 1'b0;
      end else begin
        state_next = ros_pkg::ST_RESET;
      end
      interval_count_next = '0;
    end else if (btn_short) begin
      if (state_next == ros_pkg::ST_PROFILE) begin
        // cycle the profile and wrap at the last one
        if (profile < ros_pkg::PROFILE_LAST) begin
          profile_next = profile + 3'd1;
        end else begin
          profile_next = '0;
        end
      end else if (run_flag_next) begin
        state_next    = ros_pkg::ST_ABORT;
        run_flag_next = 1'b0;
      end else if (state_next == ros_pkg::ST_IDLE) begin
        start_pending_next = 1'b1;
      end else begin
        state_next = ros_pkg::ST_RESET;
      end
      interval_count_next = '0;
    end

    // One-second run timers.
    if (run_flag_next && second_count_next >= ros_pkg::MS_PER_SECOND) begin
      second_count_next = second_count_next - ros_pkg::MS_PER_SECOND;
      run_count_next    = ros_pkg::sat_inc16(run_count);
      zone_count_next   = ros_pkg::sat_inc16(zone_count);
    end

    // At most one state machine step per sample.
    if (interval_count_next >= regs.interval_ms) begin
      interval_count_next = interval_count_next - regs.interval_ms;
      unique case (state_next)
        ros_pkg::ST_RESET: begin
          run_count_next  = '0;
          zone_count_next = '0;
          pid_en_next     = 1'b0;
          run_flag_next   = 1'b0;
          zone_next       = ros_pkg::ZN_PREHEAT;
          fan_next        = 1'b0;
          state_next      = ros_pkg::ST_IDLE;
        end
        ros_pkg::ST_IDLE: begin
          if (s_temp >= regs.room_temp) begin
            state_next = ros_pkg::ST_HOT;
          end else if (s_debug) begin
            state_next = ros_pkg::ST_DEBUG;
          end else if (start_pending_next) begin
            start_pending_next = 1'b0;
            state_next         = ros_pkg::ST_START;
          end
        end
        ros_pkg::ST_START: begin
          pid_en_next       = 1'b1;
          zone_count_next   = '0;
          zone_next         = ros_pkg::ZN_PREHEAT;
          state_next        = ros_pkg::ST_PREHEAT;
          run_flag_next     = 1'b1;
          second_count_next = '0;
        end
        ros_pkg::ST_PREHEAT: begin
          if (s_temp >= step_target) begin
            zone_count_next = '0;
            zone_next       = ros_pkg::ZN_SOAK;
            state_next      = ros_pkg::ST_SOAK;
          end
        end
        ros_pkg::ST_SOAK: begin
          if (s_temp >= step_target) begin
            zone_count_next = '0;
            zone_next       = ros_pkg::ZN_REFLOW;
            state_next      = ros_pkg::ST_REFLOW;
          end
        end
        ros_pkg::ST_REFLOW: begin
          if (s_temp >= step_target) begin
            zone_count_next = '0;
            zone_next       = ros_pkg::ZN_COOL;
            state_next      = ros_pkg::ST_COOL;
          end
        end
        ros_pkg::ST_COOL: begin
          if (s_temp < step_target) begin
            run_flag_next = 1'b0;
            state_next    = ros_pkg::ST_COMPLETE;
          end else begin
            fan_next = 1'b1;
          end
        end
        ros_pkg::ST_COMPLETE: begin
          // PID stays enabled until the next reset
          fan_next = (s_temp >= regs.room_temp);
        end
        ros_pkg::ST_HOT: begin
          if (s_temp < regs.room_temp) begin
            state_next = ros_pkg::ST_IDLE;
            fan_next   = 1'b0;
          end else begin
            fan_next = 1'b1;
          end
        end
        ros_pkg::ST_PROFILE: ;
        ros_pkg::ST_DEBUG: begin
          if (!s_debug) begin
            state_next = ros_pkg::ST_RESET;
          end
        end
        default: begin
          // abort and any stray code fall back to reset
          state_next = ros_pkg::ST_RESET;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ros_pkg::ST_RESET;
      run_flag       <= 1'b0;
      zone           <= ros_pkg::ZN_PREHEAT;
      pid_en         <= 1'b0;
      fan            <= 1'b0;
      start_pending  <= 1'b0;
      second_count   <= '0;
      interval_count <= '0;
      run_count      <= '0;
      zone_count     <= '0;
      profile        <= '0;
    end else if (advance) begin
      state          <= state_next;
      run_flag       <= run_flag_next;
      zone           <= zone_next;
      pid_en         <= pid_en_next;
      fan            <= fan_next;
      start_pending  <= start_pending_next;
      second_count   <= second_count_next;
      interval_count <= interval_count_next;
      run_count      <= run_count_next;
      zone_count     <= zone_count_next;
      profile        <= profile_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: load on advance, drop after the downstream transfer.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.state_code     <= ros_pkg::state_code(state_next);
      result.run_on         <= run_flag_next;
      result.zone_code      <= zone_next;
      result.pid_on         <= pid_en_next;
      result.setpoint       <= ros_pkg::zone_target(regs, zone_next);
      result.fan_on         <= fan_next;
      result.profile_number <= profile_next;
      result.run_seconds    <= run_count_next;
      result.zone_seconds   <= zone_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // A run always has the heater PID enabled.
  `ROS_ASSERT_IMPL(a_run_has_pid, run_flag, pid_en)
  // No run is active while waiting, hot or selecting a profile.
  `ROS_ASSERT_IMPL(a_no_run_when_parked,
    state == ros_pkg::ST_IDLE || state == ros_pkg::ST_HOT || state == ros_pkg::ST_PROFILE,
    !run_flag)
  // The fan stays off while heating through preheat and soak.
  `ROS_ASSERT_IMPL(a_fan_off_heating,
    state == ros_pkg::ST_PREHEAT || state == ros_pkg::ST_SOAK, !fan)
  // A held sample stays in the input stage while the result register is blocked.
  `ROS_ASSERT_NEXT(a_stage_holds, s_valid && !advance, s_valid)

endmodule
`default_nettype wire

// ===== hw/rtl/ros_cfg.sv =====
// Configuration register file of the reflow oven sequencer.
`default_nettype none
module ros_cfg (
  input  wire logic    clk,
  input  wire logic    rst,
  ros_cfg_if.sink      cfg,
  output ros_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.room_temp    <= 12'd200;
      regs.preheat_temp <= 12'd600;
      regs.soak_temp    <= 12'd720;
      regs.reflow_temp  <= 12'd920;
      regs.cool_temp    <= 12'd400;
      regs.interval_ms  <= 16'd1000;
    end else if (cfg.valid) begin
      // drop writes beyond the register list
      unique case (cfg.index)
        ros_pkg::CFG_ROOM:     regs.room_temp    <= cfg.data[ros_pkg::TEMP_W-1:0];
        ros_pkg::CFG_PREHEAT:  regs.preheat_temp <= cfg.data[ros_pkg::TEMP_W-1:0];
        ros_pkg::CFG_SOAK:     regs.soak_temp    <= cfg.data[ros_pkg::TEMP_W-1:0];
        ros_pkg::CFG_REFLOW:   regs.reflow_temp  <= cfg.data[ros_pkg::TEMP_W-1:0];
        ros_pkg::CFG_COOL:     regs.cool_temp    <= cfg.data[ros_pkg::TEMP_W-1:0];
        ros_pkg::CFG_INTERVAL: regs.interval_ms  <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
